// File: hw/rtl/soundex_code_encoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Soundex code encoder
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SOUNDEX_CODE_ENCODER_ASSERT_SVH
`define SOUNDEX_CODE_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SDX_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sdx assertion failed");

// Next-cycle implication
`define SDX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sdx assertion failed");

`else

`define SDX_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SDX_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: hw/rtl/sdx_pkg.sv
// ---------------------------------------------------------------------------
// sdx_pkg
// Types, constants and the letter-to-group table of the Soundex encoder.
// ---------------------------------------------------------------------------
package sdx_pkg;

    localparam int LetterW  = 7;
    localparam int DigitW   = 6;
    localparam int GroupW   = 3;
    localparam int NumDigits = 3;
    localparam int FillW    = 2;

    // ASCII base of the digit characters ('0')
    localparam logic [DigitW-1:0] DIGIT_BASE = 6'h30;

    // Group code meaning no digit (vowels, H, W, Y, non-letters)
    localparam logic [GroupW-1:0] GROUP_NONE = 3'd0;

    typedef logic [GroupW-1:0] group_t;

    // One input request
    typedef struct packed {
        logic [LetterW-1:0] letter;
        logic               word_end;
    } in_item_t;

    // One finished code
    typedef struct packed {
        logic [LetterW-1:0] lead_char;
        logic [DigitW-1:0]  digit_one;
        logic [DigitW-1:0]  digit_two;
        logic [DigitW-1:0]  digit_three;
    } code_t;

    // Letter to Soundex group; anything outside A-Z has no group
    function automatic group_t letter_group(input logic [LetterW-1:0] ch);
        group_t g;
        unique case ({1'b0, ch})
            "B", "F", "P", "V":                     g = 3'd1;
            "C", "G", "J", "K", "Q", "S", "X", "Z": g = 3'd2;
            "D", "T":                               g = 3'd3;
            "L":                                    g = 3'd4;
            "M", "N":                               g = 3'd5;
            "R":                                    g = 3'd6;
            default:                                g = GROUP_NONE;
        endcase
        return g;
    endfunction

    // Group code to ASCII digit character
    function automatic logic [DigitW-1:0] group_char(input group_t g);
        return DIGIT_BASE | {{(DigitW-GroupW){1'b0}}, g};
    endfunction

endpackage

// File: hw/rtl/sdx_in_reg.sv
// ---------------------------------------------------------------------------
// sdx_in_reg
// Input register: holds one letter request until the word stage takes it.
// ---------------------------------------------------------------------------
module sdx_in_reg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  sdx_pkg::in_item_t           s_item,
    input  logic                        take,
    output logic                        item_valid,
    output sdx_pkg::in_item_t           item
);

    logic              valid_reg;
    logic              valid_next;
    sdx_pkg::in_item_t item_reg;

    // free when empty or when the held request leaves this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hw/rtl/sdx_word_state.sv
// ---------------------------------------------------------------------------
// sdx_word_state
// Per-word state: first letter, previous group and the placed digits.
// ---------------------------------------------------------------------------
module sdx_word_state (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              go,
    input  sdx_pkg::in_item_t item,
    output sdx_pkg::code_t    code
);

    logic                                  at_start_reg, at_start_next;
    logic [sdx_pkg::LetterW-1:0]           first_reg, first_next;
    sdx_pkg::group_t                       prev_reg, prev_next;
    logic [sdx_pkg::FillW-1:0]             fill_reg, fill_next;
    sdx_pkg::group_t [sdx_pkg::NumDigits-1:0] digits_reg, digits_next;
    sdx_pkg::group_t                       grp;

    assign grp = sdx_pkg::letter_group(item.letter);

    // letter update, then clear back to word start on the last letter
    always_comb begin
        at_start_next = at_start_reg;
        first_next    = first_reg;
        prev_next     = prev_reg;
        fill_next     = fill_reg;
        digits_next   = digits_reg;
        if (at_start_reg) begin
            first_next    = item.letter;
            prev_next     = grp;
            fill_next     = '0;
            digits_next   = '0;
            at_start_next = 1'b0;
        end else if (fill_reg < sdx_pkg::FillW'(sdx_pkg::NumDigits)) begin
            if (grp != sdx_pkg::GROUP_NONE && grp != prev_reg) begin
                digits_next[fill_reg] = grp;
                fill_next             = fill_reg + 1'b1;
            end
            prev_next = grp;
        end

        // result view of the updated word
        code.lead_char   = first_next;
        code.digit_one   = sdx_pkg::group_char(digits_next[0]);
        code.digit_two   = sdx_pkg::group_char(digits_next[1]);
        code.digit_three = sdx_pkg::group_char(digits_next[2]);

        if (item.word_end) begin
            at_start_next = 1'b1;
            prev_next     = sdx_pkg::GROUP_NONE;
            fill_next     = '0;
            digits_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg <= 1'b1;
            first_reg    <= '0;
            prev_reg     <= sdx_pkg::GROUP_NONE;
            fill_reg     <= '0;
            digits_reg   <= '0;
        end else if (go) begin
            at_start_reg <= at_start_next;
            first_reg    <= first_next;
            prev_reg     <= prev_next;
            fill_reg     <= fill_next;
            digits_reg   <= digits_next;
        end
    end

endmodule

// File: hw/rtl/sdx_out_reg.sv
// ---------------------------------------------------------------------------
// sdx_out_reg
// Result register: holds one finished code until the consumer takes it.
// ---------------------------------------------------------------------------
module sdx_out_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  sdx_pkg::code_t code,
    output logic           free,
    output logic           m_valid,
    input  logic           m_ready,
    output sdx_pkg::code_t m_code
);

    logic           valid_reg;
    logic           valid_next;
    sdx_pkg::code_t code_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= code;
        end
    end

    assign m_valid = valid_reg;
    assign m_code  = code_reg;

endmodule

// File: hw/rtl/soundex_code_encoder.sv
// ---------------------------------------------------------------------------
// soundex_code_encoder
// Streaming Soundex encoder: one letter per request, one code per word.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_letter, s_word_end
//  m_      | out       | m_valid / m_ready  | m_lead_char, m_digit_one..three
//
//  One letter per cycle sustained while no last letter waits for the result
//  register; a last letter's code is loaded into the result register as the
//  letter leaves the input register, and m_valid rises with that load.
//  aresetn (synchronous) clears both registers and returns to word start.
//  A last letter waits in the input register while the result register
//  holds a code the consumer has not taken; letters behind it wait as well.
// ---------------------------------------------------------------------------
`include "soundex_code_encoder_assert.svh"

module soundex_code_encoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sdx_pkg::LetterW-1:0]   s_letter,
    input  logic                          s_word_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sdx_pkg::LetterW-1:0]   m_lead_char,
    output logic [sdx_pkg::DigitW-1:0]    m_digit_one,
    output logic [sdx_pkg::DigitW-1:0]    m_digit_two,
    output logic [sdx_pkg::DigitW-1:0]    m_digit_three
);

    sdx_pkg::in_item_t s_item;
    sdx_pkg::in_item_t item;
    sdx_pkg::code_t    code;
    sdx_pkg::code_t    m_code;
    logic              item_valid;
    logic              out_free;
    logic              stage_go;

    assign s_item.letter   = s_letter;
    assign s_item.word_end = s_word_end;

    // a last letter needs room in the result register
    assign stage_go = item_valid && (!item.word_end || out_free);

    sdx_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (stage_go),
        .item_valid (item_valid),
        .item       (item)
    );

    sdx_word_state u_word_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (stage_go),
        .item    (item),
        .code    (code)
    );

    sdx_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (stage_go && item.word_end),
        .code    (code),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_code  (m_code)
    );

    assign m_lead_char   = m_code.lead_char;
    assign m_digit_one   = m_code.digit_one;
    assign m_digit_two   = m_code.digit_two;
    assign m_digit_three = m_code.digit_three;

    // checks
    `SDX_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, m_valid && !m_ready && item_valid && item.word_end, !stage_go)
    `SDX_ASSERT_NEXT(a_last_gives_code, aclk, aresetn, stage_go && item.word_end, m_valid)
    `SDX_ASSERT_NEXT(a_mid_word_no_code, aclk, aresetn, stage_go && !item.word_end, m_valid == $past(m_valid && !m_ready))
    `SDX_ASSERT_IMPL(a_digit_range, aclk, aresetn, m_valid, m_digit_one >= 6'h30 && m_digit_one <= 6'h36 && m_digit_three >= 6'h30 && m_digit_three <= 6'h36)

endmodule
